// ===== rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared widths, codes and record types of the leveled undo trail stack.
// ----------------------------------------------------------------------------
package lts_pkg;

   localparam int TRAIL_DEPTH = 1024;
   localparam int STORE_WORDS = 256;
   localparam int VALUE_BITS  = 32;

   localparam int TRAIL_AW = $clog2(TRAIL_DEPTH);
   localparam int STORE_AW = $clog2(STORE_WORDS);

   localparam int KEY_BITS   = 16;
   localparam int KIND_BITS  = 3;
   localparam int CORR_BITS  = 16;
   localparam int LEVEL_BITS = 10;

   localparam logic [LEVEL_BITS-1:0] LEVEL_LIMIT = LEVEL_BITS'(1023);
   localparam logic [TRAIL_AW-1:0]   TRAIL_LAST  = TRAIL_AW'(TRAIL_DEPTH - 1);
   localparam logic [KEY_BITS-1:0]   KEY_LAST    = KEY_BITS'(STORE_WORDS - 1);

   // trail entry kinds
   localparam logic [KIND_BITS-1:0] KIND_UNDO      = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_CORR      = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_UNDEFINED = 3'd7;

   typedef enum logic [2:0] {
      OP_MARK       = 3'd0,
      OP_UNDO_PUSH  = 3'd1,
      OP_HIST_PUSH  = 3'd2,
      OP_RELEASE    = 3'd3,
      OP_READ_STORE = 3'd4,
      OP_READ_TRAIL = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_LEVEL_ZERO = 2'd2,
      STATUS_BAD_ARG    = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   first;
      logic [VALUE_BITS-1:0] second;
      logic [KIND_BITS-1:0]  kind;
      logic [CORR_BITS-1:0]  corr;
      logic [LEVEL_BITS-1:0] level;
   } entry_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] new_value;
      logic [KIND_BITS-1:0]  kind;
      logic [CORR_BITS-1:0]  corr;
      logic [TRAIL_AW-1:0]   index;
   } cmd_type;

   typedef struct packed {
      status_type            status;
      logic [VALUE_BITS-1:0] read_value;
      logic [KEY_BITS-1:0]   entry_first;
      logic [KIND_BITS-1:0]  entry_kind;
      logic [CORR_BITS-1:0]  entry_corr;
      logic [LEVEL_BITS-1:0] entry_level;
      logic [TRAIL_AW-1:0]   fill;
      logic [LEVEL_BITS-1:0] level;
      logic [LEVEL_BITS-1:0] peak;
   } result_type;

endpackage

// ===== rtl/lts_if.sv =====
// ----------------------------------------------------------------------------
// lts_req_if / lts_rsp_if
// Valid/ready channels for requests and results of the trail stack.
// ----------------------------------------------------------------------------
interface lts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [15:0] key;
   logic signed [31:0] new_value;
   logic [2:0]  history_kind;
   logic [15:0] correlation;
   logic [9:0]  entry_index;

   modport source (output valid, opcode, key, new_value, history_kind, correlation,
                   entry_index, input ready);
   modport sink   (input valid, opcode, key, new_value, history_kind, correlation,
                   entry_index, output ready);
endinterface

interface lts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic signed [31:0] read_value;
   logic [15:0] entry_first;
   logic [2:0]  entry_kind;
   logic [15:0] entry_correlation;
   logic [9:0]  entry_level;
   logic [9:0]  stack_fill;
   logic [9:0]  current_level;
   logic [9:0]  highest_level;

   modport source (output valid, status, read_value, entry_first, entry_kind,
                   entry_correlation, entry_level, stack_fill, current_level,
                   highest_level, input ready);
   modport sink   (input valid, status, read_value, entry_first, entry_kind,
                   entry_correlation, entry_level, stack_fill, current_level,
                   highest_level, output ready);
endinterface

// ===== rtl/lts_ram.sv =====
// ----------------------------------------------------------------------------
// lts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/leveled_undo_trail_stack.sv =====
// ----------------------------------------------------------------------------
// leveled_undo_trail_stack
// Trail stack for backtracking search with a data store beside it.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle. Mark, pushes and reads
// read the trail and store RAMs when the request is accepted, then update and
// form the result in the execute state. A release walks the entries of the
// current level in the pop loop, one trail entry per cycle, bounded by the
// single read port of the trail RAM. A result waits in the output register
// while the next request is already being worked; if that register is still
// full when the next result is ready, the sequencer holds it until the slot
// frees. No clearing pass is needed after reset: the data store keeps one
// valid bit per word, and an unwritten word reads as zero.
module leveled_undo_trail_stack
   import lts_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   lts_req_if.sink   req_bus,
   lts_rsp_if.source rsp_bus,
   input  logic   csr_write_enable,
   input  logic   csr_write_data
);

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_POP  = 4'b0100,
      S_HOLD = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   logic [TRAIL_AW-1:0]   fill_ff, fill_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [LEVEL_BITS-1:0] peak_ff, peak_in;
   logic                  keep_ff;
   logic [STORE_WORDS-1:0] store_valid_ff;

   result_type rsp_ff, rsp_in, hold_ff, hold_in, res;
   logic       rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                  store_we;
   logic [STORE_AW-1:0]   store_waddr;
   logic [VALUE_BITS-1:0] store_wdata;
   logic [STORE_AW-1:0]   store_raddr;
   logic [VALUE_BITS-1:0] store_rdata;
   logic                  trail_we;
   logic [TRAIL_AW-1:0]   trail_waddr;
   entry_type             trail_wdata;
   logic [TRAIL_AW-1:0]   trail_raddr;
   logic [$bits(entry_type)-1:0] trail_rbits;
   entry_type             trail_rdata;

   logic accept, finish, slot_free, key_bad, trail_full;
   logic [VALUE_BITS-1:0] store_word;

   assign accept      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign slot_free   = !rsp_valid_ff || rsp_bus.ready;
   assign trail_rdata = entry_type'(trail_rbits);

   // bad address is checked on the full key before any fullness test
   assign key_bad    = cmd_ff.key > KEY_LAST;
   assign trail_full = fill_ff >= TRAIL_LAST;
   // never-written store words read as zero
   assign store_word = store_valid_ff[cmd_ff.key[STORE_AW-1:0]] ? store_rdata
                                                                 : '0;

   // reads are issued at accept; during the pop loop the trail port follows
   // the next fill value so the registered read data holds the new top entry
   assign store_raddr = req_bus.key[STORE_AW-1:0];
   assign trail_raddr = (state_ff == S_IDLE && req_bus.opcode == OP_READ_TRAIL) ?
                        req_bus.entry_index : fill_in;

   lts_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_WORDS)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   lts_ram #(.WIDTH($bits(entry_type)), .DEPTH(TRAIL_DEPTH)) u_trail (
      .clock   (clock),
      .wr_en   (trail_we),
      .wr_addr (trail_waddr),
      .wr_data (trail_wdata),
      .rd_addr (trail_raddr),
      .rd_data (trail_rbits)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      level_in     = level_ff;
      peak_in      = peak_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      finish       = 1'b0;
      store_we     = 1'b0;
      store_waddr  = cmd_ff.key[STORE_AW-1:0];
      store_wdata  = cmd_ff.new_value;
      trail_we     = 1'b0;
      trail_waddr  = fill_ff + 1'b1;
      trail_wdata  = '{first: cmd_ff.key, second: cmd_ff.new_value,
                       kind: cmd_ff.kind, corr: '0, level: level_ff};
      res          = '0;
      res.status   = STATUS_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = '{opcode: req_bus.opcode, key: req_bus.key,
                          new_value: req_bus.new_value, kind: req_bus.history_kind,
                          corr: req_bus.correlation, index: req_bus.entry_index};
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            finish = 1'b1;
            case (cmd_ff.opcode)
               OP_MARK: begin
                  if (level_ff >= LEVEL_LIMIT) begin
                     res.status = STATUS_FULL;
                  end else begin
                     level_in = level_ff + 1'b1;
                     if (level_in > peak_ff) begin
                        peak_in = level_in;
                     end
                  end
               end
               OP_UNDO_PUSH: begin
                  if (key_bad) begin
                     res.status = STATUS_BAD_ARG;
                  end else if (trail_full) begin
                     res.status = STATUS_FULL;
                  end else begin
                     trail_we           = 1'b1;
                     trail_wdata.second = store_word;
                     trail_wdata.kind   = KIND_UNDO;
                     store_we           = 1'b1;
                     fill_in            = fill_ff + 1'b1;
                  end
               end
               OP_HIST_PUSH: begin
                  if (cmd_ff.kind == KIND_UNDO || cmd_ff.kind == KIND_UNDEFINED) begin
                     res.status = STATUS_BAD_ARG;
                  end else if (trail_full) begin
                     res.status = STATUS_FULL;
                  end else begin
                     trail_we = 1'b1;
                     if (cmd_ff.kind == KIND_CORR) begin
                        trail_wdata.corr = cmd_ff.corr;
                     end
                     fill_in = fill_ff + 1'b1;
                  end
               end
               OP_RELEASE: begin
                  if (level_ff == '0) begin
                     res.status = STATUS_LEVEL_ZERO;
                  end else begin
                     finish   = 1'b0;
                     state_in = S_POP;
                  end
               end
               OP_READ_STORE: begin
                  if (key_bad) begin
                     res.status = STATUS_BAD_ARG;
                  end else begin
                     res.read_value = store_word;
                  end
               end
               OP_READ_TRAIL: begin
                  if (cmd_ff.index == '0 || cmd_ff.index > fill_ff) begin
                     res.status = STATUS_BAD_ARG;
                  end else begin
                     res.read_value  = trail_rdata.second;
                     res.entry_first = trail_rdata.first;
                     res.entry_kind  = trail_rdata.kind;
                     res.entry_corr  = trail_rdata.corr;
                     res.entry_level = trail_rdata.level;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP: begin
            // trail_rdata holds the entry at the current top
            if (fill_ff != '0 && trail_rdata.level == level_ff) begin
               if (trail_rdata.kind == KIND_UNDO && !keep_ff &&
                   trail_rdata.first <= KEY_LAST) begin
                  store_we    = 1'b1;
                  store_waddr = trail_rdata.first[STORE_AW-1:0];
                  store_wdata = trail_rdata.second;
               end
               fill_in = fill_ff - 1'b1;
            end else begin
               level_in = level_ff - 1'b1;
               finish   = 1'b1;
            end
         end
         S_HOLD: begin
            if (slot_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // counters in the result are those after the operation
      res.fill  = fill_in;
      res.level = level_in;
      res.peak  = peak_in;

      if (finish) begin
         if (slot_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         level_ff       <= '0;
         peak_ff        <= '0;
         keep_ff        <= 1'b0;
         store_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         level_ff     <= level_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            keep_ff <= csr_write_data;
         end
         if (store_we) begin
            store_valid_ff[store_waddr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status            = rsp_ff.status;
   assign rsp_bus.read_value        = rsp_ff.read_value;
   assign rsp_bus.entry_first       = rsp_ff.entry_first;
   assign rsp_bus.entry_kind        = rsp_ff.entry_kind;
   assign rsp_bus.entry_correlation = rsp_ff.entry_corr;
   assign rsp_bus.entry_level       = rsp_ff.entry_level;
   assign rsp_bus.stack_fill        = rsp_ff.fill;
   assign rsp_bus.current_level     = rsp_ff.level;
   assign rsp_bus.highest_level     = rsp_ff.peak;

   // peak tracks the open level count
   a_peak_covers_level: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= level_ff)
      else $error("highest level below current level");

   // each pop cycle removes one entry, or closes the level and ends
   a_pop_progress: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |=>
         (fill_ff + 1'b1 == $past(fill_ff)) || (level_ff + 1'b1 == $past(level_ff)))
      else $error("release loop made no progress");

   // a held result only exists while the output slot is occupied
   a_hold_needs_busy_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("result held with free output slot");

   // keep mode never restores store words
   a_keep_no_restore: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && keep_ff) |-> !store_we)
      else $error("store restored in keep mode");

endmodule

// ===== tb/lts_result_checker.sv =====
// ----------------------------------------------------------------------------
// lts_result_checker
// Watches the request, result and csr ports of the trail stack, keeps its own
// copy of the store, trail and level counters, and compares every result
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module lts_result_checker
   import lts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lts_req_if   req_mon,
   lts_rsp_if   rsp_mon,
   input  logic csr_write_enable,
   input  logic csr_write_data,
   output int   fault_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 200;

   // shadow state
   logic [VALUE_BITS-1:0] store_words   [STORE_WORDS];
   logic [KEY_BITS-1:0]   trail_first   [TRAIL_DEPTH];
   logic [VALUE_BITS-1:0] trail_second  [TRAIL_DEPTH];
   logic [KIND_BITS-1:0]  trail_kind    [TRAIL_DEPTH];
   logic [CORR_BITS-1:0]  trail_corr    [TRAIL_DEPTH];
   logic [LEVEL_BITS-1:0] trail_level   [TRAIL_DEPTH];
   logic [TRAIL_AW-1:0]   fill_ptr;
   logic [LEVEL_BITS-1:0] open_levels;
   logic [LEVEL_BITS-1:0] peak_level;
   logic                  keep_mode;

   result_type expected_results[$];
   int         error_count = 0;

   function automatic void append_trail_entry(input logic [KEY_BITS-1:0] first,
                                              input logic [VALUE_BITS-1:0] second,
                                              input logic [KIND_BITS-1:0] kind,
                                              input logic [CORR_BITS-1:0] corr);
      fill_ptr = fill_ptr + 1'b1;
      trail_first[fill_ptr]  = first;
      trail_second[fill_ptr] = second;
      trail_kind[fill_ptr]   = kind;
      trail_corr[fill_ptr]   = corr;
      trail_level[fill_ptr]  = open_levels;
   endfunction

   function automatic result_type predict_trail_op(input cmd_type c);
      result_type r;
      logic       trail_full;
      r = '0;
      r.status = STATUS_OK;
      trail_full = (fill_ptr >= TRAIL_LAST);
      case (c.opcode)
         OP_MARK: begin
            if (open_levels >= LEVEL_LIMIT) begin
               r.status = STATUS_FULL;
            end else begin
               open_levels = open_levels + 1'b1;
               if (open_levels > peak_level) peak_level = open_levels;
            end
         end
         OP_UNDO_PUSH: begin
            // address is checked ahead of fullness
            if (c.key > KEY_LAST) begin
               r.status = STATUS_BAD_ARG;
            end else if (trail_full) begin
               r.status = STATUS_FULL;
            end else begin
               append_trail_entry(c.key, store_words[c.key[STORE_AW-1:0]], KIND_UNDO, '0);
               store_words[c.key[STORE_AW-1:0]] = c.new_value;
            end
         end
         OP_HIST_PUSH: begin
            if (c.kind == KIND_UNDO || c.kind == KIND_UNDEFINED) begin
               r.status = STATUS_BAD_ARG;
            end else if (trail_full) begin
               r.status = STATUS_FULL;
            end else begin
               append_trail_entry(c.key, c.new_value, c.kind,
                                  (c.kind == KIND_CORR) ? c.corr : '0);
            end
         end
         OP_RELEASE: begin
            if (open_levels == '0) begin
               r.status = STATUS_LEVEL_ZERO;
            end else begin
               while (fill_ptr != '0 && trail_level[fill_ptr] == open_levels) begin
                  if (trail_kind[fill_ptr] == KIND_UNDO && !keep_mode &&
                      trail_first[fill_ptr] <= KEY_LAST)
                     store_words[trail_first[fill_ptr][STORE_AW-1:0]] = trail_second[fill_ptr];
                  fill_ptr = fill_ptr - 1'b1;
               end
               open_levels = open_levels - 1'b1;
            end
         end
         OP_READ_STORE: begin
            if (c.key > KEY_LAST) r.status = STATUS_BAD_ARG;
            else r.read_value = store_words[c.key[STORE_AW-1:0]];
         end
         OP_READ_TRAIL: begin
            if (c.index == '0 || c.index > fill_ptr) begin
               r.status = STATUS_BAD_ARG;
            end else begin
               r.read_value  = trail_second[c.index];
               r.entry_first = trail_first[c.index];
               r.entry_kind  = trail_kind[c.index];
               r.entry_corr  = trail_corr[c.index];
               r.entry_level = trail_level[c.index];
            end
         end
         default: ;
      endcase
      r.fill  = fill_ptr;
      r.level = open_levels;
      r.peak  = peak_level;
      return r;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         if (error_count < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      cmd_type    seen;
      result_type want;
      if (reset) begin
         for (int i = 0; i < STORE_WORDS; i++) store_words[i] = '0;
         for (int i = 0; i < TRAIL_DEPTH; i++) begin
            trail_first[i]  = '0;
            trail_second[i] = '0;
            trail_kind[i]   = '0;
            trail_corr[i]   = '0;
            trail_level[i]  = '0;
         end
         fill_ptr    = '0;
         open_levels = '0;
         peak_level  = '0;
         keep_mode   = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) keep_mode = csr_write_data;
         // results first, a result can never belong to a request taken at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: result with nothing expected, actual status %0d fill %0d",
                           $time, rsp_mon.status, rsp_mon.stack_fill);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               report_field("status", 32'(want.status), 32'(rsp_mon.status));
               report_field("read_value", want.read_value, rsp_mon.read_value);
               report_field("entry_first", 32'(want.entry_first), 32'(rsp_mon.entry_first));
               report_field("entry_kind", 32'(want.entry_kind), 32'(rsp_mon.entry_kind));
               report_field("entry_correlation", 32'(want.entry_corr),
                            32'(rsp_mon.entry_correlation));
               report_field("entry_level", 32'(want.entry_level), 32'(rsp_mon.entry_level));
               report_field("stack_fill", 32'(want.fill), 32'(rsp_mon.stack_fill));
               report_field("current_level", 32'(want.level), 32'(rsp_mon.current_level));
               report_field("highest_level", 32'(want.peak), 32'(rsp_mon.highest_level));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            seen.opcode    = req_mon.opcode;
            seen.key       = req_mon.key;
            seen.new_value = req_mon.new_value;
            seen.kind      = req_mon.history_kind;
            seen.corr      = req_mon.correlation;
            seen.index     = req_mon.entry_index;
            expected_results.push_back(predict_trail_op(seen));
         end
      end
      // results still owed count as faults too
      fault_count = error_count + expected_results.size();
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the leveled undo trail stack: directed corner
// cases, random mixes of marks, pushes, releases and reads under both keep
// mode settings, and a climb to a full trail.
// ----------------------------------------------------------------------------
module tb
   import lts_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // opcodes the block treats as no operation
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int QUIET_LIMIT  = 8000;   // longest release plus stalls, several times over
   localparam int TAIL_CYCLES  = 32;
   localparam int PHASE_ITEMS  = 90;
   localparam int DEEP_ITEMS   = 100;
   localparam int CLIMB_STEPS  = 1040;   // pushes, enough to fill the trail from empty
   localparam int MARK_EVERY   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic csr_write_data;
   logic stall_enable;

   int sent = 0;
   int received = 0;
   int quiet_cycles = 0;
   int keep_writes = 0;
   int fault_count;

   lts_req_if req_bus();
   lts_rsp_if rsp_bus();

   leveled_undo_trail_stack dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lts_result_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fault_count      (fault_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side stalls at random while stalling is enabled
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= !(stall_enable && $urandom_range(0, 99) < 29);
   end

   // handshake counters and the watchdog on silent cycles
   always @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) sent <= sent + 1;
      if (rsp_bus.valid && rsp_bus.ready) received <= received + 1;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic cmd_type make_cmd(input logic [2:0] op, input logic [15:0] key,
                                        input logic [31:0] value, input logic [2:0] kind,
                                        input logic [15:0] corr, input logic [9:0] index);
      cmd_type c;
      c.opcode    = op;
      c.key       = key;
      c.new_value = value;
      c.kind      = kind;
      c.corr      = corr;
      c.index     = index;
      return c;
   endfunction

   // mostly a few hot words so undo records pile up on the same address
   function automatic logic [15:0] rand_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 16'($urandom_range(0, 15));
      else if (pick < 92) return 16'($urandom_range(0, 255));
      else return 16'($urandom_range(0, 65535));
   endfunction

   // well-formed push, undo or history, with random content
   function automatic cmd_type random_push();
      cmd_type c;
      c = make_cmd(OP_UNDO_PUSH, 16'($urandom_range(0, 255)), $urandom(),
                   3'($urandom), 16'($urandom), 10'($urandom));
      if ($urandom_range(0, 2) == 0) begin
         c.opcode = OP_HIST_PUSH;
         c.key    = 16'($urandom);
         c.kind   = 3'($urandom_range(1, 6));
      end
      return c;
   endfunction

   // one request of the random mix; unused fields carry junk
   function automatic cmd_type random_request();
      cmd_type c;
      int      pick;
      c = make_cmd(OP_MARK, 16'($urandom), $urandom(), 3'($urandom), 16'($urandom),
                   10'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         c.opcode = OP_MARK;
      end else if (pick < 42) begin
         c.opcode = OP_UNDO_PUSH;
         c.key    = rand_key();
      end else if (pick < 56) begin
         c.opcode = OP_HIST_PUSH;
         c.kind   = 3'($urandom_range(1, 6));
      end else if (pick < 67) begin
         c.opcode = OP_RELEASE;
      end else if (pick < 80) begin
         c.opcode = OP_READ_STORE;
         c.key    = rand_key();
      end else if (pick < 95) begin
         c.opcode = OP_READ_TRAIL;
         pick = $urandom_range(0, 99);
         if (pick < 80) c.index = 10'($urandom_range(1, 48));
         else if (pick < 95) c.index = 10'($urandom_range(0, 1023));
         else c.index = '0;
      end else begin
         // noise: spare opcodes and malformed pushes
         case ($urandom_range(0, 3))
            0: c.opcode = OP_SPARE_A;
            1: c.opcode = OP_SPARE_B;
            2: begin
               c.opcode = OP_HIST_PUSH;
               c.kind   = ($urandom_range(0, 1) == 0) ? KIND_UNDO : KIND_UNDEFINED;
            end
            default: begin
               c.opcode = OP_UNDO_PUSH;
               c.key    = 16'($urandom_range(256, 65535));
            end
         endcase
      end
      return c;
   endfunction

   // hold valid low for a random gap, then present the request until taken
   task automatic issue(input cmd_type c);
      int gap;
      gap = 0;
      while (stall_enable && $urandom_range(0, 99) < 29) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= c.opcode;
      req_bus.key          <= c.key;
      req_bus.new_value    <= c.new_value;
      req_bus.history_kind <= c.kind;
      req_bus.correlation  <= c.corr;
      req_bus.entry_index  <= c.index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // every request has a result, so equal counts mean the block is idle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
   endtask

   task automatic set_keep_mode(input logic keep);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= keep;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      keep_writes++;
   endtask

   // one deep level so a release walks a long run of entries
   task automatic deep_level(input int depth);
      issue(make_cmd(OP_MARK, '0, '0, '0, '0, '0));
      repeat (depth) issue(random_push());
      issue(make_cmd(OP_RELEASE, '0, '0, '0, '0, '0));
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.opcode       = '0;
      req_bus.key          = '0;
      req_bus.new_value    = '0;
      req_bus.history_kind = '0;
      req_bus.correlation  = '0;
      req_bus.entry_index  = '0;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      stall_enable         = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, keep mode off from reset
      issue(make_cmd(OP_READ_STORE, 16'd0, '0, '0, '0, '0));          // cleared word
      issue(make_cmd(OP_READ_STORE, 16'd256, '0, '0, '0, '0));        // just past the store
      issue(make_cmd(OP_READ_STORE, 16'hFFFF, '0, '0, '0, '0));
      issue(make_cmd(OP_RELEASE, '0, '0, '0, '0, '0));                // release at level zero
      issue(make_cmd(OP_READ_TRAIL, '0, '0, '0, '0, 10'd0));          // index zero
      issue(make_cmd(OP_READ_TRAIL, '0, '0, '0, '0, 10'd1));          // empty trail
      issue(make_cmd(OP_UNDO_PUSH, 16'd0, 32'h7FFF_FFFF, '0, '0, '0)); // level zero entry
      issue(make_cmd(OP_MARK, '0, '0, '0, '0, '0));
      issue(make_cmd(OP_UNDO_PUSH, 16'd0, 32'h8000_0000, '0, 16'hFFFF, '0));
      issue(make_cmd(OP_UNDO_PUSH, 16'd255, 32'hFFFF_FFFF, '0, '0, '0));
      issue(make_cmd(OP_UNDO_PUSH, 16'd256, 32'h1234_5678, '0, '0, '0)); // bad address
      issue(make_cmd(OP_HIST_PUSH, 16'd1, '0, KIND_UNDO, '0, '0));       // bad kinds
      issue(make_cmd(OP_HIST_PUSH, 16'd1, '0, KIND_UNDEFINED, '0, '0));
      issue(make_cmd(OP_HIST_PUSH, 16'hFFFF, '0, KIND_CORR, 16'hFFFF, '0));
      issue(make_cmd(OP_HIST_PUSH, 16'h0000, 32'h8000_0000, 3'd1, 16'hFFFF, '0)); // corr dropped
      issue(make_cmd(OP_HIST_PUSH, 16'h5A5A, 32'h7FFF_FFFF, 3'd5, 16'h1234, '0));
      issue(make_cmd(OP_READ_TRAIL, '0, '0, '0, '0, 10'd4));
      issue(make_cmd(OP_READ_TRAIL, '0, '0, '0, '0, 10'd5));
      issue(make_cmd(OP_READ_TRAIL, '0, '0, '0, '0, 10'd7));          // one past the fill
      issue(make_cmd(OP_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 10'h3FF));
      issue(make_cmd(OP_SPARE_B, '0, '0, '0, '0, '0));
      issue(make_cmd(OP_RELEASE, '0, '0, '0, '0, '0));                // restores both words
      issue(make_cmd(OP_READ_STORE, 16'd0, '0, '0, '0, '0));
      issue(make_cmd(OP_READ_STORE, 16'd255, '0, '0, '0, '0));
      issue(make_cmd(OP_RELEASE, '0, '0, '0, '0, '0));                // release at level zero again

      // random mixes under alternating keep mode
      set_keep_mode(1'b1);
      repeat (PHASE_ITEMS) issue(random_request());
      set_keep_mode(1'b0);
      deep_level(DEEP_ITEMS);
      repeat (PHASE_ITEMS) issue(random_request());
      set_keep_mode(1'b1);
      deep_level(DEEP_ITEMS);
      repeat (PHASE_ITEMS) issue(random_request());
      set_keep_mode(1'b0);
      repeat (PHASE_ITEMS) issue(random_request());

      // climb to a full trail with a new level every few pushes,
      // the first stretch with no stalls
      stall_enable <= 1'b0;
      for (int step = 0; step < CLIMB_STEPS; step++) begin
         if (step == 500) stall_enable <= 1'b1;
         if (step % MARK_EVERY == 0)
            issue(make_cmd(OP_MARK, 16'($urandom), $urandom(), 3'($urandom), 16'($urandom),
                           10'($urandom)));
         issue(random_push());
      end
      // poke around at the top with a full trail
      repeat (80) issue(random_request());

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d requests and took %0d results, keep mode written %0d times",
               sent, received, keep_writes);
      $display("covered corner cases, random mixes, long releases and a full trail");
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/lts_ram.sv
rtl/leveled_undo_trail_stack.sv
tb/lts_result_checker.sv
tb/tb.sv
